FILE: hdl/tcs_pkg.sv
// Shared types for the type-check stack: operation codes, status codes and
// the shift commands that the top level issues to the register stack.
// No dependencies.
`default_nettype none

package tcs_pkg;

    // Operation codes carried in s_opcode
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_BINARY = 3'd2,
        OP_PAIR   = 3'd3,
        OP_SINGLE = 3'd4
    } opcode_t;

    // Status codes carried in m_status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDER    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVER     = 2'd3
    } status_t;

    // Shift commands for the register stack
    typedef enum logic [2:0] {
        STK_HOLD     = 3'd0,
        STK_PUSH     = 3'd1,
        STK_POP1     = 3'd2,
        STK_POP2     = 3'd3,
        STK_POP2_PUT = 3'd4
    } stk_op_t;

endpackage

`default_nettype wire

FILE: hdl/type_check_stack.sv
// Type-check stack: a bounded stack of type tags with push, pop and three
// check operations; one status beat per operation beat.
// Depends on tcs_pkg and tcs_shift_stack.
//
// One operation beat is accepted every cycle while s_ready is high, and
// its result beat appears on the m_ channel in the next cycle. The stack
// is a shift register whose entry 0 is always the top, so every operation
// reads only the top two entries and updates every entry of the stack
// together. An output register holds the result, and s_ready stays high
// while that register is empty or being drained. Underflow and overflow
// leave the stack unchanged; a failed check still consumes its operands.
`default_nettype none

module type_check_stack #(
    parameter int TAG_WIDTH   = 4,
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [2:0]                            s_opcode,
    input  wire logic [TAG_WIDTH-1:0]                  s_type_tag,
    input  wire logic [TAG_WIDTH-1:0]                  s_result_type,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [1:0]                                 m_status,
    output logic [TAG_WIDTH-1:0]                       m_top_type,
    output logic [$clog2(STACK_DEPTH+1)-1:0]           m_stack_count
);
    import tcs_pkg::*;

    localparam int CNT_WIDTH = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(STACK_DEPTH);
    localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);

    logic                 s_fire;
    stk_op_t              stk_op;
    logic [TAG_WIDTH-1:0] stk_tag;
    status_t              status;
    logic [TAG_WIDTH-1:0] top0;
    logic [TAG_WIDTH-1:0] top1;
    logic [CNT_WIDTH-1:0] count;
    logic [TAG_WIDTH-1:0] top_next;
    logic [CNT_WIDTH-1:0] count_next;
    logic                 empty;

    logic                 m_valid_reg;
    status_t              status_reg;
    logic [TAG_WIDTH-1:0] top_reg;
    logic [CNT_WIDTH-1:0] count_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign empty   = (count == '0);

    // Decode the operation beat into a stack shift and a status
    always_comb begin
        stk_op  = STK_HOLD;
        stk_tag = s_type_tag;
        status  = ST_OK;
        case (s_opcode)
            OP_PUSH: begin
                if (count == CNT_FULL) begin
                    status = ST_OVER;
                end else begin
                    stk_op = STK_PUSH;
                end
            end
            OP_POP: begin
                if (empty) begin
                    status = ST_UNDER;
                end else begin
                    stk_op = STK_POP1;
                end
            end
            OP_BINARY: begin
                if (count <= CNT_ONE) begin
                    status = ST_UNDER;
                end else if (top0 == s_type_tag && top1 == s_type_tag) begin
                    stk_op  = STK_POP2_PUT;
                    stk_tag = s_result_type;
                end else begin
                    stk_op = STK_POP2;
                    status = ST_MISMATCH;
                end
            end
            OP_PAIR: begin
                if (count <= CNT_ONE) begin
                    status = ST_UNDER;
                end else begin
                    stk_op = STK_POP2;
                    if (top0 != top1) begin
                        status = ST_MISMATCH;
                    end
                end
            end
            OP_SINGLE: begin
                if (empty) begin
                    status = ST_UNDER;
                end else begin
                    stk_op = STK_POP1;
                    if (top0 != s_type_tag) begin
                        status = ST_MISMATCH;
                    end
                end
            end
            default: begin
                stk_op = STK_HOLD;
            end
        endcase
        // Drop the shift unless the beat is taken
        if (!s_fire) begin
            stk_op = STK_HOLD;
        end
    end

    tcs_shift_stack #(
        .TAG_WIDTH   (TAG_WIDTH),
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_WIDTH   (CNT_WIDTH)
    ) u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stk_op     (stk_op),
        .stk_tag    (stk_tag),
        .top0       (top0),
        .top1       (top1),
        .count      (count),
        .top_next   (top_next),
        .count_next (count_next)
    );

    // Hold the result beat until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status;
            top_reg    <= (count_next == '0) ? '0 : top_next;
            count_reg  <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_top_type    = top_reg;
    assign m_stack_count = count_reg;

endmodule

`default_nettype wire

FILE: hdl/tcs_shift_stack.sv
// Register stack of type tags: entry 0 is always the top, and every entry
// shifts by one or two places on a push or a pop. Depends on tcs_pkg.
`default_nettype none

module tcs_shift_stack #(
    parameter int TAG_WIDTH   = 4,
    parameter int STACK_DEPTH = 64,
    parameter int CNT_WIDTH   = 7
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  tcs_pkg::stk_op_t          stk_op,
    input  wire logic [TAG_WIDTH-1:0] stk_tag,
    output logic [TAG_WIDTH-1:0]      top0,
    output logic [TAG_WIDTH-1:0]      top1,
    output logic [CNT_WIDTH-1:0]      count,
    output logic [TAG_WIDTH-1:0]      top_next,
    output logic [CNT_WIDTH-1:0]      count_next
);
    import tcs_pkg::*;

    localparam logic [CNT_WIDTH-1:0] CNT_ONE = CNT_WIDTH'(1);
    localparam logic [CNT_WIDTH-1:0] CNT_TWO = CNT_WIDTH'(2);

    logic [TAG_WIDTH-1:0] entry_reg  [STACK_DEPTH];
    logic [TAG_WIDTH-1:0] entry_next [STACK_DEPTH];
    logic [CNT_WIDTH-1:0] count_reg;

    // Select each entry's next value from its neighbors
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_entry
        logic [TAG_WIDTH-1:0] below_val;
        logic [TAG_WIDTH-1:0] above1_val;
        logic [TAG_WIDTH-1:0] above2_val;
        logic [TAG_WIDTH-1:0] put_val;

        if (i == 0) begin : g_bottom_in
            assign below_val = stk_tag;
        end else begin : g_bottom_shift
            assign below_val = entry_reg[i-1];
        end

        if (i + 1 < STACK_DEPTH) begin : g_up1
            assign above1_val = entry_reg[i+1];
        end else begin : g_up1_edge
            assign above1_val = entry_reg[i];
        end

        if (i + 2 < STACK_DEPTH) begin : g_up2
            assign above2_val = entry_reg[i+2];
        end else begin : g_up2_edge
            assign above2_val = entry_reg[i];
        end

        // Two pops and one push: new top is the pushed tag, the rest move up one
        if (i == 0) begin : g_put_top
            assign put_val = stk_tag;
        end else begin : g_put_rest
            assign put_val = above1_val;
        end

        assign entry_next[i] = (stk_op == STK_PUSH)     ? below_val  :
                               (stk_op == STK_POP1)     ? above1_val :
                               (stk_op == STK_POP2)     ? above2_val :
                               (stk_op == STK_POP2_PUT) ? put_val    :
                                                          entry_reg[i];
    end

    // Advance the fill count
    always_comb begin
        case (stk_op)
            STK_PUSH:     count_next = count_reg + CNT_ONE;
            STK_POP1:     count_next = count_reg - CNT_ONE;
            STK_POP2:     count_next = count_reg - CNT_TWO;
            STK_POP2_PUT: count_next = count_reg - CNT_ONE;
            default:      count_next = count_reg;
        endcase
    end

    // Hold the tag entries (contents are meaningless until pushed)
    always_ff @(posedge aclk) begin
        for (int k = 0; k < STACK_DEPTH; k++) begin
            entry_reg[k] <= entry_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign top0     = entry_reg[0];
    assign top1     = entry_reg[1];
    assign count    = count_reg;
    assign top_next = entry_next[0];

endmodule

`default_nettype wire
